// ===== hdl/fca_pkg.sv =====
// ============================================================================
// fca_pkg: shared types and constants of the chain allocator
// Holds the action and status codes, the link table tags, and the command
// and status structs that join the controller and the datapath.
// ============================================================================
package fca_pkg;

  // Field widths of the stream beats.
  localparam int unsigned ActW   = 2;
  localparam int unsigned HeadW  = 11;
  localparam int unsigned CountW = 6;
  localparam int unsigned StatW  = 2;
  localparam int unsigned BlkW   = 11;
  localparam int unsigned NumW   = 12;
  // Width of the saturated run counter (holds MAX_RUN up to 127).
  localparam int unsigned KW     = 7;

  // Link table tags: a link to block b is stored as b + LinkBase.
  localparam int unsigned TagFree  = 0;
  localparam int unsigned TagEnd   = 1;
  localparam int unsigned LinkBase = 2;

  typedef enum logic [1:0] {
    ACT_CREATE = 2'd0,
    ACT_EXTEND = 2'd1,
    ACT_READ   = 2'd2,
    ACT_FREE   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BROKEN  = 2'd2,
    ST_RSVD    = 2'd3
  } stat_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LOAD_HEAD,
    OP_FREE_CUR,
    OP_WALK,
    OP_VADV,
    OP_ROST,
    OP_FIND_START,
    OP_FIND_NEXT,
    OP_ALLOC_END,
    OP_LINK_CUR,
    OP_STEP_K
  } dp_op_e;

  typedef enum logic [2:0] {
    RD_CUR,
    RD_NX,
    RD_HEAD,
    RD_HINT,
    RD_PTR_INC
  } rd_sel_e;

  typedef enum logic [2:0] {
    RES_NOSPACE_ZERO,
    RES_NOSPACE_HEAD,
    RES_BROKEN,
    RES_OK_HEAD,
    RES_OK_CUR
  } res_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd;
    logic    emit;
    res_e    res;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic clr_done;
    logic rd_zero;
    logic rd_end;
    logic rd_link;
    logic nx_ok;
    logic nx_is_cur;
    logic k_done;
    logic cnt_zero;
    logic room_ok;
    logic used_full;
    logic head_ok;
    logic steps_over;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/fca_ram.sv =====
// ============================================================================
// fca_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module fca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fca_dp.sv =====
// ============================================================================
// fca_dp: datapath of the chain allocator
// Link table RAM, chain cursor, scan pointer, counters and result register.
// ============================================================================
module fca_dp #(
  parameter int unsigned NUM_BLOCKS = 2048,
  parameter int unsigned MAX_RUN    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fca_pkg::cmd_t               cmd_i,
  output fca_pkg::sts_t               sts_o,
  input  logic [fca_pkg::ActW-1:0]    action_i,
  input  logic [fca_pkg::HeadW-1:0]   chain_head_i,
  input  logic [fca_pkg::CountW-1:0]  block_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fca_pkg::StatW-1:0]   status_o,
  output logic [fca_pkg::BlkW-1:0]    block_index_o,
  output logic [fca_pkg::NumW-1:0]    freed_count_o,
  output logic [fca_pkg::NumW-1:0]    blocks_in_use_o,
  output logic                        last_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned EW = $clog2(NUM_BLOCKS + 2);
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned KW = fca_pkg::KW;
  localparam int unsigned RW = ((CW > KW) ? CW : KW) + 1;

  fca_pkg::act_e              act_q;
  logic [fca_pkg::HeadW-1:0]  head_q;
  logic [KW-1:0]              cnt_q, k_q;
  logic [AW-1:0]              cur_q, ptr_q;
  logic [CW-1:0]              steps_q, freed_q, used_q, hint_q;

  logic                       out_valid_q;
  logic [fca_pkg::StatW-1:0]  out_stat_q;
  logic [fca_pkg::BlkW-1:0]   out_blk_q;
  logic [fca_pkg::NumW-1:0]   out_freed_q, out_used_q;
  logic                       out_last_q;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [EW-1:0]   wdata, rdata, nx;
  logic [AW-1:0]   nx_addr, head_addr;
  logic [KW-1:0]   cnt_in;
  logic            out_free;

  fca_ram #(.WIDTH(EW), .DEPTH(NUM_BLOCKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign nx        = rdata - EW'(fca_pkg::LinkBase);
  assign nx_addr   = AW'(nx);
  assign head_addr = AW'(head_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign cnt_in    = (KW'(block_count_i) > KW'(MAX_RUN)) ? KW'(MAX_RUN) : KW'(block_count_i);

  always_comb begin
    case (cmd_i.rd)
      fca_pkg::RD_NX:      raddr = nx_addr;
      fca_pkg::RD_HEAD:    raddr = head_addr;
      fca_pkg::RD_HINT:    raddr = AW'(hint_q);
      fca_pkg::RD_PTR_INC: raddr = ptr_q + AW'(1);
      default:             raddr = cur_q;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = EW'(fca_pkg::TagFree);
    case (cmd_i.op)
      fca_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_q;
      end
      fca_pkg::OP_FREE_CUR: begin
        we = 1'b1;
      end
      fca_pkg::OP_LINK_CUR: begin
        we    = 1'b1;
        wdata = EW'(ptr_q) + EW'(fca_pkg::LinkBase);
      end
      fca_pkg::OP_ALLOC_END: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = EW'(fca_pkg::TagEnd);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Control registers: scan pointer, counts and lowest-free hint.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      used_q  <= '0;
      hint_q  <= '0;
      freed_q <= '0;
    end else begin
      case (cmd_i.op)
        fca_pkg::OP_CLEAR:       ptr_q <= ptr_q + AW'(1);
        fca_pkg::OP_ACCEPT:      freed_q <= '0;
        fca_pkg::OP_FIND_START:  ptr_q <= AW'(hint_q);
        fca_pkg::OP_FIND_NEXT:   ptr_q <= ptr_q + AW'(1);
        fca_pkg::OP_FREE_CUR: begin
          freed_q <= freed_q + CW'(1);
          if (used_q != '0) begin
            used_q <= used_q - CW'(1);
          end
          if (CW'(cur_q) < hint_q) begin
            hint_q <= CW'(cur_q);
          end
        end
        fca_pkg::OP_ALLOC_END: begin
          used_q <= used_q + CW'(1);
          hint_q <= CW'(ptr_q) + CW'(1);
        end
        default: begin
          ptr_q <= ptr_q;
        end
      endcase
    end
  end

  // Operation payload registers.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      fca_pkg::OP_ACCEPT: begin
        act_q  <= fca_pkg::act_e'(action_i);
        head_q <= chain_head_i;
        cnt_q  <= cnt_in;
      end
      fca_pkg::OP_LOAD_HEAD: begin
        cur_q   <= head_addr;
        k_q     <= KW'(1);
        steps_q <= '0;
      end
      fca_pkg::OP_FREE_CUR:  cur_q <= nx_addr;
      fca_pkg::OP_WALK: begin
        cur_q   <= nx_addr;
        steps_q <= steps_q + CW'(1);
      end
      fca_pkg::OP_VADV: begin
        cur_q <= nx_addr;
        k_q   <= k_q + KW'(1);
      end
      fca_pkg::OP_ROST: begin
        cur_q <= head_addr;
        k_q   <= KW'(1);
      end
      fca_pkg::OP_ALLOC_END: cur_q <= ptr_q;
      fca_pkg::OP_STEP_K:    k_q <= k_q + KW'(1);
      default: begin
        cur_q <= cur_q;
      end
    endcase
  end

  // Result register: loads when the controller emits and the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_freed_q <= (cmd_i.res == fca_pkg::RES_OK_HEAD) ? fca_pkg::NumW'(freed_q) : '0;
      out_used_q  <= fca_pkg::NumW'(used_q);
      out_last_q  <= cmd_i.fin || (k_q == cnt_q);
      case (cmd_i.res)
        fca_pkg::RES_NOSPACE_ZERO: begin
          out_stat_q <= fca_pkg::ST_NOSPACE;
          out_blk_q  <= '0;
        end
        fca_pkg::RES_NOSPACE_HEAD: begin
          out_stat_q <= fca_pkg::ST_NOSPACE;
          out_blk_q  <= head_q;
        end
        fca_pkg::RES_BROKEN: begin
          out_stat_q <= fca_pkg::ST_BROKEN;
          out_blk_q  <= head_q;
        end
        fca_pkg::RES_OK_HEAD: begin
          out_stat_q <= fca_pkg::ST_OK;
          out_blk_q  <= head_q;
        end
        default: begin
          out_stat_q <= fca_pkg::ST_OK;
          out_blk_q  <= fca_pkg::BlkW'(cur_q);
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_stat_q;
  assign block_index_o   = out_blk_q;
  assign freed_count_o   = out_freed_q;
  assign blocks_in_use_o = out_used_q;
  assign last_o          = out_last_q;

  always_comb begin
    sts_o.act        = act_q;
    sts_o.clr_done   = (ptr_q == AW'(NUM_BLOCKS - 1));
    sts_o.rd_zero    = (rdata == EW'(fca_pkg::TagFree));
    sts_o.rd_end     = (rdata == EW'(fca_pkg::TagEnd));
    sts_o.rd_link    = (rdata >= EW'(fca_pkg::LinkBase));
    sts_o.nx_ok      = (nx < EW'(NUM_BLOCKS));
    sts_o.nx_is_cur  = (nx == EW'(cur_q));
    sts_o.k_done     = (k_q == cnt_q);
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.room_ok    = (RW'(cnt_q) <= (RW'(NUM_BLOCKS) - RW'(used_q)));
    sts_o.used_full  = (used_q >= CW'(NUM_BLOCKS));
    sts_o.head_ok    = (32'(head_q) < 32'(NUM_BLOCKS));
    sts_o.steps_over = (steps_q >= CW'(NUM_BLOCKS));
    sts_o.out_free   = out_free;
  end

endmodule

// ===== hdl/fca_ctrl.sv =====
// ============================================================================
// fca_ctrl: controller of the chain allocator
// Sequences the clearing pass, chain walks, free scans and result beats.
// ============================================================================
module fca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fca_pkg::sts_t sts_i,
  output fca_pkg::cmd_t cmd_o
);

  typedef enum logic [15:0] {
    S_CLR      = 16'h0001,
    S_IDLE     = 16'h0002,
    S_DISP     = 16'h0004,
    S_HEV      = 16'h0008,
    S_FREV     = 16'h0010,
    S_RVEV     = 16'h0020,
    S_ROST     = 16'h0040,
    S_ROEV     = 16'h0080,
    S_XEV      = 16'h0100,
    S_FIND_ST  = 16'h0200,
    S_FIND_EV  = 16'h0400,
    S_CR_WR    = 16'h0800,
    S_X_LINK   = 16'h1000,
    S_X_END    = 16'h2000,
    S_X_EMIT   = 16'h4000,
    S_EMIT_FIN = 16'h8000
  } state_e;

  state_e        state_q, state_d;
  fca_pkg::res_e fin_res_q, fin_res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      fin_res_q <= fca_pkg::RES_OK_HEAD;
    end else begin
      state_q   <= state_d;
      fin_res_q <= fin_res_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    fin_res_d = fin_res_q;
    cmd_o     = '{op: fca_pkg::OP_NONE, rd: fca_pkg::RD_CUR, emit: 1'b0,
                  res: fca_pkg::RES_OK_CUR, fin: 1'b0};
    case (state_q)
      S_CLR: begin
        cmd_o.op = fca_pkg::OP_CLEAR;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = fca_pkg::OP_ACCEPT;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.act == fca_pkg::ACT_CREATE) begin
          if (sts_i.used_full) begin
            fin_res_d = fca_pkg::RES_NOSPACE_ZERO;
            state_d   = S_EMIT_FIN;
          end else begin
            state_d = S_FIND_ST;
          end
        end else if (!sts_i.head_ok) begin
          fin_res_d = fca_pkg::RES_BROKEN;
          state_d   = S_EMIT_FIN;
        end else begin
          cmd_o.op = fca_pkg::OP_LOAD_HEAD;
          cmd_o.rd = fca_pkg::RD_HEAD;
          state_d  = S_HEV;
        end
      end
      S_HEV: begin
        if (sts_i.rd_zero) begin
          fin_res_d = fca_pkg::RES_BROKEN;
          state_d   = S_EMIT_FIN;
        end else if (sts_i.act == fca_pkg::ACT_FREE) begin
          state_d = S_FREV;
        end else if (sts_i.cnt_zero) begin
          fin_res_d = fca_pkg::RES_OK_HEAD;
          state_d   = S_EMIT_FIN;
        end else if (sts_i.act == fca_pkg::ACT_READ) begin
          state_d = S_RVEV;
        end else if (!sts_i.room_ok) begin
          fin_res_d = fca_pkg::RES_NOSPACE_HEAD;
          state_d   = S_EMIT_FIN;
        end else begin
          state_d = S_XEV;
        end
      end
      S_FREV: begin
        if (sts_i.rd_zero) begin
          fin_res_d = fca_pkg::RES_OK_HEAD;
          state_d   = S_EMIT_FIN;
        end else begin
          cmd_o.op = fca_pkg::OP_FREE_CUR;
          cmd_o.rd = fca_pkg::RD_NX;
          if (!sts_i.rd_link || !sts_i.nx_ok || sts_i.nx_is_cur) begin
            fin_res_d = fca_pkg::RES_OK_HEAD;
            state_d   = S_EMIT_FIN;
          end
        end
      end
      S_RVEV: begin
        if (sts_i.rd_zero) begin
          fin_res_d = fca_pkg::RES_BROKEN;
          state_d   = S_EMIT_FIN;
        end else if (sts_i.k_done) begin
          state_d = S_ROST;
        end else if (!sts_i.rd_link || !sts_i.nx_ok) begin
          fin_res_d = fca_pkg::RES_BROKEN;
          state_d   = S_EMIT_FIN;
        end else begin
          cmd_o.op = fca_pkg::OP_VADV;
          cmd_o.rd = fca_pkg::RD_NX;
        end
      end
      S_ROST: begin
        cmd_o.op = fca_pkg::OP_ROST;
        cmd_o.rd = fca_pkg::RD_HEAD;
        state_d  = S_ROEV;
      end
      S_ROEV: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.k_done) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = fca_pkg::OP_VADV;
            cmd_o.rd = fca_pkg::RD_NX;
          end
        end
      end
      S_XEV: begin
        if (sts_i.rd_zero) begin
          fin_res_d = fca_pkg::RES_BROKEN;
          state_d   = S_EMIT_FIN;
        end else if (sts_i.rd_end) begin
          state_d = S_FIND_ST;
        end else if (sts_i.steps_over || !sts_i.nx_ok) begin
          fin_res_d = fca_pkg::RES_BROKEN;
          state_d   = S_EMIT_FIN;
        end else begin
          cmd_o.op = fca_pkg::OP_WALK;
          cmd_o.rd = fca_pkg::RD_NX;
        end
      end
      S_FIND_ST: begin
        cmd_o.op = fca_pkg::OP_FIND_START;
        cmd_o.rd = fca_pkg::RD_HINT;
        state_d  = S_FIND_EV;
      end
      S_FIND_EV: begin
        if (sts_i.rd_zero) begin
          state_d = (sts_i.act == fca_pkg::ACT_CREATE) ? S_CR_WR : S_X_LINK;
        end else begin
          cmd_o.op = fca_pkg::OP_FIND_NEXT;
          cmd_o.rd = fca_pkg::RD_PTR_INC;
        end
      end
      S_CR_WR: begin
        cmd_o.op  = fca_pkg::OP_ALLOC_END;
        fin_res_d = fca_pkg::RES_OK_CUR;
        state_d   = S_EMIT_FIN;
      end
      S_X_LINK: begin
        cmd_o.op = fca_pkg::OP_LINK_CUR;
        state_d  = S_X_END;
      end
      S_X_END: begin
        cmd_o.op = fca_pkg::OP_ALLOC_END;
        state_d  = S_X_EMIT;
      end
      S_X_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.k_done) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = fca_pkg::OP_STEP_K;
            state_d  = S_FIND_ST;
          end
        end
      end
      S_EMIT_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.res  = fin_res_q;
          cmd_o.fin  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

endmodule

// ===== hdl/fat_chain_allocator_top.sv =====
// ============================================================================
// fat_chain_allocator_top: file allocation table chain manager
// Creates, extends, reads and frees block chains in a table of next-block
// links and keeps a count of the blocks in use.
// ============================================================================
//
// Channel  Dir  Bits  Contents
// -------  ---  ----  --------------------------------------------------------
// s_*      in   24    action[1:0], chain_head[12:2], block_count[18:13]
// m_*      out  40    status[1:0], block_index[12:2], freed_count[24:13],
//                     blocks_in_use[36:25]; tlast marks the final beat
//
// After reset a clearing pass writes every table entry to free, and no input
// beat is taken until it ends. The block then works on one input beat at a
// time. The table has one read port that returns one entry per cycle, so a
// walk follows one link at a time and a free-block scan probes one entry at a
// time, starting at the lowest block that may be free. Create scans for one
// block; read checks the chain, then walks it again from the head; free walks
// and frees the chain; extend walks to its end and then appends each block.
// A result waits in an output register, so a stalled master side holds the
// work at the next result beat while the next input beat may still be taken
// once the current one is finished.
//
module fat_chain_allocator_top #(
  parameter int unsigned NUM_BLOCKS = 2048,
  parameter int unsigned MAX_RUN    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // action, chain_head, block_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status, block_index, freed_count, blocks_in_use
  output logic        m_tlast
);

  fca_pkg::cmd_t cmd;
  fca_pkg::sts_t sts;

  logic [fca_pkg::StatW-1:0] status;
  logic [fca_pkg::BlkW-1:0]  block_index;
  logic [fca_pkg::NumW-1:0]  freed_count;
  logic [fca_pkg::NumW-1:0]  blocks_in_use;

  // The controller owns sequencing; it sees the datapath only through status.
  fca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fca_dp #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_RUN    (MAX_RUN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (s_tdata[1:0]),
    .chain_head_i    (s_tdata[12:2]),
    .block_count_i   (s_tdata[18:13]),
    .out_valid_o     (m_tvalid),
    .out_ready_i     (m_tready),
    .status_o        (status),
    .block_index_o   (block_index),
    .freed_count_o   (freed_count),
    .blocks_in_use_o (blocks_in_use),
    .last_o          (m_tlast)
  );

  // Result beat packing, lowest field first, padded to whole bytes.
  assign m_tdata = {3'b000, blocks_in_use, freed_count, block_index, status};

endmodule
